FILE: hw/rtl/sala_pkg.sv
package sala_pkg;

   localparam int TAG_W     = 32;
   localparam int SET_MAX_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int LEN_W     = 13;
   localparam int DIRTY_W   = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_ORIGIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd2;

   localparam logic [3:0] BLOCK_SHIFT_MAX   = 4'd12;
   localparam logic [3:0] BLOCK_SHIFT_RESET = 4'd6;
   localparam logic [2:0] SET_BITS_RESET    = 3'd6;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             valid;
      logic             dirty;
   } line_type;

   typedef struct packed {
      logic                 op;
      logic                 err;
      logic                 partial;
      logic [SET_MAX_W-1:0] set;
      logic [TAG_W-1:0]     tag;
   } item_type;

endpackage

FILE: hw/rtl/sala_req_if.sv
interface sala_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] address;
   logic [12:0] length;

   modport source (output valid, output op, output address, output length, input ready);
   modport sink (input valid, input op, input address, input length, output ready);
endinterface

FILE: hw/rtl/sala_rsp_if.sv
interface sala_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic        evicted;
   logic        writeback;
   logic [31:0] evicted_tag;
   logic        fill_before_write;
   logic        line_error;
   logic [8:0]  dirty_lines;

   modport source (output valid, output hit, output evicted, output writeback,
                   output evicted_tag, output fill_before_write, output line_error,
                   output dirty_lines, input ready);
   modport sink (input valid, input hit, input evicted, input writeback,
                 input evicted_tag, input fill_before_write, input line_error,
                 input dirty_lines, output ready);
endinterface

FILE: hw/rtl/sala_csr_if.sv
interface sala_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/sala_front.sv
module sala_front #(
   parameter int ADDR_BITS = 32,
   parameter int SETS      = 64
) (
   sala_req_if.sink             req_port,
   input  logic [31:0]          mem_origin,
   input  logic [3:0]           block_shift,
   input  logic [2:0]           set_bits,
   output sala_pkg::item_type   item,
   output logic                 item_valid,
   input  logic                 item_ready
);
   import sala_pkg::*;

   localparam int SET_LOG = $clog2(SETS + 1) - 1;
   localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                   32'((64'd1 << ADDR_BITS) - 64'd1);

   logic [3:0]  bs;
   logic [3:0]  sb;
   logic [4:0]  low_bits;
   logic [31:0] rel;
   logic [31:0] last;
   logic [31:0] set_full;

   always_comb begin
      bs       = (block_shift > BLOCK_SHIFT_MAX) ? BLOCK_SHIFT_MAX : block_shift;
      sb       = ({1'b0, set_bits} > 4'(SET_LOG)) ? 4'(SET_LOG) : {1'b0, set_bits};
      low_bits = {1'b0, bs} + {1'b0, sb};
      rel      = (req_port.address - mem_origin) & AMASK;
      last     = (rel + 32'(req_port.length) - 32'd1) & AMASK;
      set_full = (rel >> bs) & ((32'd1 << sb) - 32'd1);
      item.op      = req_port.op;
      item.err     = (rel >> bs) != (last >> bs);
      item.partial = (req_port.op == OP_WRITE) && (req_port.length != (13'd1 << bs));
      item.set     = set_full[SET_MAX_W-1:0];
      item.tag     = rel & ~((32'd1 << low_bits) - 32'd1) & AMASK;
   end

   assign item_valid     = req_port.valid;
   assign req_port.ready = item_ready;

endmodule

FILE: hw/rtl/sala_queue.sv
module sala_queue (
   input  logic               clock,
   input  logic               reset,
   input  sala_pkg::item_type push_item,
   input  logic               push_valid,
   output logic               push_ready,
   output sala_pkg::item_type pop_item,
   output logic               pop_valid,
   input  logic               pop_ready
);
   import sala_pkg::*;

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/sala_back.sv
module sala_back #(
   parameter int WAYS = 4,
   parameter int SETS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  sala_pkg::item_type q_item,
   input  logic               q_valid,
   output logic               q_ready,
   sala_rsp_if.source         rsp_port
);
   import sala_pkg::*;

   localparam int SIDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINES  = WAYS * SETS;
   localparam int CNT_W  = $clog2(LINES + 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   typedef line_type [WAYS-1:0] row_type;

   row_type mem [SETS];

   logic [1:0]        state_ff, state_in;
   logic [SIDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   item_type          cur_ff;
   row_type           rd_ff;
   logic              rd_en;
   logic              mem_we;
   logic [SIDX_W-1:0] mem_wa;
   row_type           mem_wd;
   row_type           new_row;

   logic              found, hit;
   logic [WAY_W-1:0]  fv, hw, victim, src;
   logic              full;
   line_type          fresh;
   logic              ev, wb;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              hit_ff, ev_ff, wb_ff, fbw_ff, err_ff;
   logic [31:0]       evtag_ff;
   logic [8:0]        dirty_ff;
   logic              load_rsp;

   always_comb begin
      found = 1'b0;
      hit   = 1'b0;
      fv    = '0;
      hw    = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (rd_ff[i].valid && !hit) begin
            if (!found) begin
               fv = WAY_W'(i);
            end
            found = 1'b1;
            if (rd_ff[i].tag == cur_ff.tag) begin
               hit = 1'b1;
               hw  = WAY_W'(i);
            end
         end
      end
      full   = found && (fv == '0);
      victim = !found ? WAY_W'(WAYS - 1) : (full ? '0 : fv - 1'b1);
      src    = full ? WAY_W'(WAYS - 1) : victim;
      ev     = !hit && rd_ff[src].valid;
      wb     = ev && rd_ff[src].dirty;
      fresh.tag   = cur_ff.tag;
      fresh.valid = 1'b1;
      fresh.dirty = (cur_ff.op == OP_WRITE);
      for (int k = 0; k < WAYS; k++) begin
         new_row[k] = rd_ff[k];
         if (hit) begin
            if (WAY_W'(k) == fv) begin
               new_row[k] = rd_ff[hw];
               if (cur_ff.op == OP_WRITE) begin
                  new_row[k].dirty = 1'b1;
               end
            end else if (WAY_W'(k) > fv && WAY_W'(k) <= hw && k > 0) begin
               new_row[k] = rd_ff[k-1];
            end
         end else if (full) begin
            new_row[k] = (k == 0) ? fresh : rd_ff[(k > 0) ? k - 1 : 0];
         end else if (WAY_W'(k) == victim) begin
            new_row[k] = fresh;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_UPDATE && !cur_ff.err) begin
         if (hit) begin
            if (cur_ff.op == OP_WRITE && !rd_ff[hw].dirty) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end else begin
            if (wb && cnt_ff != '0) begin
               cnt_in = cnt_in - 1'b1;
            end
            if (cur_ff.op == OP_WRITE) begin
               cnt_in = cnt_in + 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      rd_en    = 1'b0;
      q_ready  = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = clr_ff;
      mem_wd   = '0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SIDX_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_port.ready)) begin
               q_ready  = 1'b1;
               rd_en    = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            load_rsp = 1'b1;
            mem_we   = !cur_ff.err;
            mem_wa   = cur_ff.set[SIDX_W-1:0];
            mem_wd   = new_row;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff  <= mem[q_item.set[SIDX_W-1:0]];
         cur_ff <= q_item;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         hit_ff   <= !cur_ff.err && hit;
         ev_ff    <= !cur_ff.err && ev;
         wb_ff    <= !cur_ff.err && wb;
         evtag_ff <= (!cur_ff.err && ev) ? rd_ff[src].tag : 32'd0;
         fbw_ff   <= !cur_ff.err && !hit && cur_ff.partial;
         err_ff   <= cur_ff.err;
         dirty_ff <= (32'(cnt_in) > 32'd511) ? 9'd511 : 9'(cnt_in);
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.hit               = hit_ff;
   assign rsp_port.evicted           = ev_ff;
   assign rsp_port.writeback         = wb_ff;
   assign rsp_port.evicted_tag       = evtag_ff;
   assign rsp_port.fill_before_write = fbw_ff;
   assign rsp_port.line_error        = err_ff;
   assign rsp_port.dirty_lines       = dirty_ff;

endmodule

FILE: hw/rtl/set_assoc_lru_writeback_tags_core.sv
// Tag controller of a set-associative write-back cache with LRU order per set.
// Each access is relocated by mem_origin, checked for crossing a line, and
// queued (two entries) ahead of the tag store. The store holds one row of
// WAYS ways per set in a memory; an access reads its row into a register, then
// writes the updated row while registering the result; the back end takes no
// new item before a pending result is taken. After reset a clear pass writes
// every row before the first item is taken. Register writes are always
// accepted and must be made while the block is idle.
module set_assoc_lru_writeback_tags_core #(
   parameter int WAYS      = 4,
   parameter int SETS      = 64,
   parameter int ADDR_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   sala_req_if.sink   req_port,
   sala_rsp_if.source rsp_port,
   sala_csr_if.sink   csr_port
);
   import sala_pkg::*;

   logic [31:0] mem_origin_ff;
   logic [3:0]  block_shift_ff;
   logic [2:0]  set_bits_ff;
   item_type    f_item, q_item;
   logic        f_valid, f_ready, q_valid, q_ready;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_origin_ff  <= '0;
         block_shift_ff <= BLOCK_SHIFT_RESET;
         set_bits_ff    <= SET_BITS_RESET;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            CSR_MEM_ORIGIN:  mem_origin_ff  <= csr_port.data;
            CSR_BLOCK_SHIFT: block_shift_ff <= csr_port.data[3:0];
            CSR_SET_BITS:    set_bits_ff    <= csr_port.data[2:0];
            default: begin
            end
         endcase
      end
   end

   sala_front #(.ADDR_BITS(ADDR_BITS), .SETS(SETS)) u_front (
      .req_port    (req_port),
      .mem_origin  (mem_origin_ff),
      .block_shift (block_shift_ff),
      .set_bits    (set_bits_ff),
      .item        (f_item),
      .item_valid  (f_valid),
      .item_ready  (f_ready)
   );

   sala_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (f_item),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .pop_item   (q_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready)
   );

   sala_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .rsp_port (rsp_port)
   );

   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.line_error |->
         !rsp_port.hit && !rsp_port.evicted && !rsp_port.writeback &&
         !rsp_port.fill_before_write)
      else $error("line error result carries other flags");

   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.writeback |-> rsp_port.evicted && !rsp_port.hit)
      else $error("write-back without eviction");

   a_fbw_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.fill_before_write |-> !rsp_port.hit)
      else $error("fill-before-write on a hit");

endmodule
